// ----- src/ebfc_pkg.sv -----
// Shared types and constants of the escaped byte framing codec.
package ebfc_pkg;

	// Byte values of the framing scheme.
	localparam logic [7:0] ESC_BYTE   = 8'h1A;
	localparam logic [7:0] CTRL_LIMIT = 8'h20;
	localparam logic [7:0] ESC_OFFSET = 8'h80;
	localparam logic [7:0] NUL_BYTE   = 8'h00;

	// Default receive frame limit in raw bytes.
	localparam int MAX_FRAME_BYTES_DEF = 256;

	// Depth of the result queue; it must hold at least two words.
	localparam int RES_DEPTH = 4;

	// Command codes of an input word.
	typedef enum logic [1:0] {
		CMD_TX_DATA = 2'd0,
		CMD_TX_TERM = 2'd1,
		CMD_RX_BYTE = 2'd2,
		CMD_UNUSED  = 2'd3
	} cmd_t;

	// One result word.
	typedef struct packed {
		logic       to_link;
		logic [7:0] out_byte;
		logic       last;
		logic       oversize;
	} result_t;

	// Up to two results handed to the queue in one cycle.
	typedef struct packed {
		logic [1:0] cnt;
		result_t    r0;
		result_t    r1;
	} push_t;

endpackage

// ----- src/ebfc_codec.sv -----
// Input register, encode and decode logic, and receive frame state.
module ebfc_codec #(
	parameter int MAX_FRAME_BYTES = ebfc_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [1:0]      command,
	input  logic [7:0]      data_byte,
	input  logic            escape_enable,
	input  logic            room,
	output ebfc_pkg::push_t push
);
	import ebfc_pkg::*;

	localparam int LW = $clog2(MAX_FRAME_BYTES + 2);
	localparam logic [LW-1:0] MAX_LEN = LW'(MAX_FRAME_BYTES);

	logic          valid_s1;
	logic [1:0]    cmd_s1;
	logic [7:0]    byte_s1;
	logic          esc_en_s1;
	logic          advance;
	logic          esc_pend_q;
	logic          esc_pend_nxt;
	logic [LW-1:0] len_q;
	logic [LW-1:0] len_nxt;
	push_t         res;

	// The held word moves on once the queue has room for two results.
	assign advance  = valid_s1 && room;
	assign in_stall = valid_s1 && !room;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			cmd_s1    <= command;
			byte_s1   <= data_byte;
			esc_en_s1 <= escape_enable;
		end
	end

	// Encode or decode the held word and work out the next receive state.
	always_comb begin
		res          = '0;
		esc_pend_nxt = esc_pend_q;
		len_nxt      = len_q;
		unique case (cmd_t'(cmd_s1))
			CMD_TX_DATA: begin
				if (esc_en_s1 && (byte_s1 < CTRL_LIMIT || byte_s1 == ESC_BYTE)) begin
					res.cnt = 2'd2;
					res.r0  = '{to_link: 1'b1, out_byte: ESC_BYTE, last: 1'b0, oversize: 1'b0};
					res.r1  = '{to_link: 1'b1, out_byte: byte_s1 + ESC_OFFSET,
						last: 1'b0, oversize: 1'b0};
				end else begin
					res.cnt = 2'd1;
					res.r0  = '{to_link: 1'b1, out_byte: byte_s1, last: 1'b0, oversize: 1'b0};
				end
			end
			CMD_TX_TERM: begin
				res.cnt = 2'd1;
				res.r0  = '{to_link: 1'b1, out_byte: NUL_BYTE, last: 1'b1, oversize: 1'b0};
			end
			CMD_RX_BYTE: begin
				if (byte_s1 == NUL_BYTE) begin
					// End of frame; an empty frame gives nothing.
					if (len_q != '0) begin
						res.cnt = 2'd1;
						res.r0  = '{to_link: 1'b0,
							out_byte: esc_pend_q ? (NUL_BYTE - ESC_OFFSET) : NUL_BYTE,
							last: 1'b1, oversize: (len_q > MAX_LEN)};
						esc_pend_nxt = 1'b0;
						len_nxt      = '0;
					end
				end else begin
					// The raw length saturates one above the limit.
					if (len_q <= MAX_LEN) begin
						len_nxt = len_q + LW'(1);
					end
					if (byte_s1 == ESC_BYTE) begin
						esc_pend_nxt = 1'b1;
					end else if (esc_pend_q) begin
						esc_pend_nxt = 1'b0;
						res.cnt      = 2'd1;
						res.r0       = '{to_link: 1'b0, out_byte: byte_s1 - ESC_OFFSET,
							last: 1'b0, oversize: 1'b0};
					end else begin
						res.cnt = 2'd1;
						res.r0  = '{to_link: 1'b0, out_byte: byte_s1, last: 1'b0, oversize: 1'b0};
					end
				end
			end
			default: begin
				res = '0;
			end
		endcase
	end

	// Receive frame state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_pend_q <= 1'b0;
			len_q      <= '0;
		end else if (advance) begin
			esc_pend_q <= esc_pend_nxt;
			len_q      <= len_nxt;
		end
	end

	// Nothing is pushed while the word is held back.
	always_comb begin
		push = res;
		if (!advance) begin
			push.cnt = 2'd0;
		end
	end

endmodule

// ----- src/ebfc_resq.sv -----
// Result queue that takes up to two words a cycle and hands out one while the output is not stalled.
module ebfc_resq (
	input  logic            clk,
	input  logic            arst_n,
	input  ebfc_pkg::push_t push,
	output logic            room,
	output logic            out_valid,
	input  logic            out_stall,
	output logic            to_link,
	output logic [7:0]      out_byte,
	output logic            last,
	output logic            oversize
);
	import ebfc_pkg::*;

	localparam int PW = $clog2(RES_DEPTH);
	localparam int CW = $clog2(RES_DEPTH + 1);

	result_t       mem_q [RES_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          pop;
	result_t       head;

	assign room      = count_q <= CW'(RES_DEPTH - 2);
	assign out_valid = count_q != '0;
	assign pop       = out_valid && !out_stall;

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wr_ptr_q + PW'(1)] <= push.r1;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(push.cnt);
			rd_ptr_q <= rd_ptr_q + PW'(pop);
			count_q  <= count_q + CW'(push.cnt) - CW'(pop);
		end
	end

	// Head word drives the output fields.
	assign head     = mem_q[rd_ptr_q];
	assign to_link  = head.to_link;
	assign out_byte = head.out_byte;
	assign last     = head.last;
	assign oversize = head.oversize;

endmodule

// ----- src/escaped_byte_framing_codec_core.sv -----
// Path: a result word passes the input register and then the result queue before it is
// offered; while the queue lacks room for two words, the word waits in the input register.
// Throughput: one input word per cycle while the result side keeps up; an escaped
// transmit byte yields two result words, and the result queue (two words a cycle in,
// one out) sets the sustained rate to one result word per cycle.
// Reset: arst_n clears the input stage, the result queue and the receive frame state.
module escaped_byte_framing_codec_core #(
	parameter int MAX_FRAME_BYTES = ebfc_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] command,
	input  logic [7:0] data_byte,
	input  logic       escape_enable,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       to_link,
	output logic [7:0] out_byte,
	output logic       last,
	output logic       oversize
);
	import ebfc_pkg::*;

	push_t push;
	logic  room;

	// Encoder, decoder and receive state.
	ebfc_codec #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_codec (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.data_byte    (data_byte),
		.escape_enable(escape_enable),
		.room         (room),
		.push         (push)
	);

	// Result queue.
	ebfc_resq u_resq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.to_link  (to_link),
		.out_byte (out_byte),
		.last     (last),
		.oversize (oversize)
	);

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for the escaped byte framing codec core.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ebfc_pkg::*;

	localparam int FRAME_LIMIT = MAX_FRAME_BYTES_DEF;
	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;
	localparam int DIRECTED_ROWS = 25;

	// One directed row: the word to send and, where typed, its expected results.
	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] b;
		logic       esc;
		logic       typed;
		logic [1:0] n;
		result_t    w0;
		result_t    w1;
	} dir_row_t;

	localparam result_t LINK_ESC = '{1'b1, ESC_BYTE, 1'b0, 1'b0};
	localparam result_t NO_WORD  = '0;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	cmd_t       command = CMD_TX_DATA;
	logic [7:0] data_byte = 8'h00;
	logic       escape_enable = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       to_link;
	logic [7:0] out_byte;
	logic       last;
	logic       oversize;

	// Receive frame state of the predictor.
	logic host_escape_pending = 1'b0;
	int   host_raw_count = 0;

	result_t pending_words[$];
	int      words_sent = 0;
	int      results_seen = 0;
	int      errors = 0;
	int      src_idle_pct = 0;
	int      rcv_stall_pct = 0;
	bit      hold_req = 1'b0;
	int      quiet_cycles = 0;

	dir_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
		'{CMD_RX_BYTE, 8'h00, 1'b0, 1'b1, 2'd0, NO_WORD, NO_WORD},
		'{CMD_TX_DATA, 8'h00, 1'b1, 1'b1, 2'd2, LINK_ESC, '{1'b1, 8'h80, 1'b0, 1'b0}},
		'{CMD_TX_DATA, 8'hFF, 1'b1, 1'b1, 2'd1, '{1'b1, 8'hFF, 1'b0, 1'b0}, NO_WORD},
		'{CMD_TX_DATA, 8'h1A, 1'b1, 1'b1, 2'd2, LINK_ESC, '{1'b1, 8'h9A, 1'b0, 1'b0}},
		'{CMD_TX_DATA, 8'h1F, 1'b1, 1'b1, 2'd2, LINK_ESC, '{1'b1, 8'h9F, 1'b0, 1'b0}},
		'{CMD_TX_DATA, 8'h20, 1'b1, 1'b1, 2'd1, '{1'b1, 8'h20, 1'b0, 1'b0}, NO_WORD},
		'{CMD_TX_DATA, 8'h05, 1'b0, 1'b1, 2'd1, '{1'b1, 8'h05, 1'b0, 1'b0}, NO_WORD},
		'{CMD_TX_DATA, 8'h1A, 1'b0, 1'b1, 2'd1, '{1'b1, 8'h1A, 1'b0, 1'b0}, NO_WORD},
		'{CMD_TX_TERM, 8'hA5, 1'b1, 1'b1, 2'd1, '{1'b1, 8'h00, 1'b1, 1'b0}, NO_WORD},
		'{CMD_RX_BYTE, 8'h41, 1'b1, 1'b0, 2'd0, NO_WORD, NO_WORD},
		'{CMD_RX_BYTE, 8'h1A, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
		'{CMD_RX_BYTE, 8'h1A, 1'b1, 1'b0, 2'd0, NO_WORD, NO_WORD},
		'{CMD_RX_BYTE, 8'hC1, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
		'{CMD_UNUSED,  8'hFF, 1'b1, 1'b1, 2'd0, NO_WORD, NO_WORD},
		'{CMD_RX_BYTE, 8'h05, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
		'{CMD_TX_DATA, 8'h1A, 1'b1, 1'b0, 2'd0, NO_WORD, NO_WORD},
		'{CMD_RX_BYTE, 8'h1A, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
		'{CMD_RX_BYTE, 8'h00, 1'b0, 1'b1, 2'd1, '{1'b0, 8'h80, 1'b1, 1'b0}, NO_WORD},
		'{CMD_RX_BYTE, 8'h00, 1'b1, 1'b1, 2'd0, NO_WORD, NO_WORD},
		'{CMD_RX_BYTE, 8'hFF, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
		'{CMD_RX_BYTE, 8'h1A, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
		'{CMD_RX_BYTE, 8'h7F, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
		'{CMD_RX_BYTE, 8'h80, 1'b1, 1'b0, 2'd0, NO_WORD, NO_WORD},
		'{CMD_RX_BYTE, 8'h00, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
		'{CMD_TX_TERM, 8'h00, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD}
	};

	escaped_byte_framing_codec_core #(
		.MAX_FRAME_BYTES(FRAME_LIMIT)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.data_byte    (data_byte),
		.escape_enable(escape_enable),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.to_link      (to_link),
		.out_byte     (out_byte),
		.last         (last),
		.oversize     (oversize)
	);

	// Free-running 10 ns clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Encodes or decodes one input word, updates the receive frame state and
	// returns how many result words it yields.
	function automatic int encode_decode_word(input cmd_t c, input logic [7:0] b,
			input logic e, output result_t w0, output result_t w1);
		logic [7:0] shifted;
		w0 = '0;
		w1 = '0;
		case (c)
			CMD_TX_DATA: begin
				if (e && (b < CTRL_LIMIT || b == ESC_BYTE)) begin
					shifted = b + ESC_OFFSET;
					w0 = LINK_ESC;
					w1 = '{1'b1, shifted, 1'b0, 1'b0};
					return 2;
				end
				w0 = '{1'b1, b, 1'b0, 1'b0};
				return 1;
			end
			CMD_TX_TERM: begin
				w0 = '{1'b1, NUL_BYTE, 1'b1, 1'b0};
				return 1;
			end
			CMD_RX_BYTE: begin
				// The delimiter closes a non-empty frame; an empty one is skipped.
				if (b == NUL_BYTE) begin
					if (host_raw_count == 0)
						return 0;
					shifted = host_escape_pending ? NUL_BYTE - ESC_OFFSET : NUL_BYTE;
					w0 = '{1'b0, shifted, 1'b1, host_raw_count > FRAME_LIMIT};
					host_escape_pending = 1'b0;
					host_raw_count = 0;
					return 1;
				end
				if (host_raw_count <= FRAME_LIMIT)
					host_raw_count++;
				if (b == ESC_BYTE) begin
					host_escape_pending = 1'b1;
					return 0;
				end
				if (host_escape_pending) begin
					host_escape_pending = 1'b0;
					shifted = b - ESC_OFFSET;
					w0 = '{1'b0, shifted, 1'b0, 1'b0};
					return 1;
				end
				w0 = '{1'b0, b, 1'b0, 1'b0};
				return 1;
			end
			default: return 0;
		endcase
	endfunction

	// Random byte biased toward escape bytes, control bytes, 8'hFF and 8'h80.
	function automatic logic [7:0] rand_byte(input bit nonzero);
		logic [7:0] b;
		case ($urandom_range(9))
			0, 1: b = ESC_BYTE;
			2, 3: b = 8'($urandom_range(31));
			4: b = $urandom_range(1) ? 8'hFF : 8'h80;
			default: b = 8'($urandom);
		endcase
		if (nonzero && b == NUL_BYTE)
			b = 8'($urandom_range(255, 1));
		return b;
	endfunction

	// Offers one word after a random gap, waits for it to be taken and queues
	// its expected results, typed in or predicted.
	task automatic drive_word(input cmd_t c, input logic [7:0] b, input logic e,
			input logic typed, input int n_typed, input result_t t0, input result_t t1);
		result_t p0;
		result_t p1;
		int n;
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		command <= c;
		data_byte <= b;
		escape_enable <= e;
		do @(posedge clk); while (in_stall);
		n = encode_decode_word(c, b, e, p0, p1);
		if (typed) begin
			n = n_typed;
			p0 = t0;
			p1 = t1;
		end
		if (n > 0)
			pending_words = {pending_words, p0};
		if (n > 1)
			pending_words = {pending_words, p1};
		if (c != CMD_UNUSED)
			words_sent++;
		@(negedge clk);
	endtask

	task automatic send_word(input cmd_t c, input logic [7:0] b, input logic e);
		drive_word(c, b, e, 1'b0, 0, NO_WORD, NO_WORD);
	endtask

	// One random sequence: mostly well-formed frames, some stray words.
	task automatic send_random_sequence();
		int kind;
		int len;
		logic [7:0] b;
		kind = $urandom_range(99);
		if (kind < 45) begin
			len = $urandom_range(12, 1);
			for (int i = 0; i < len; i++) begin
				b = rand_byte(1'b1);
				if (i == len - 1 && $urandom_range(3) == 0)
					b = ESC_BYTE;
				send_word(CMD_RX_BYTE, b, 1'($urandom));
				// Transmit words interleaved into a receive frame.
				if ($urandom_range(9) == 0)
					send_word(CMD_TX_DATA, rand_byte(1'b0), 1'($urandom));
			end
			send_word(CMD_RX_BYTE, NUL_BYTE, 1'($urandom));
			if ($urandom_range(4) == 0)
				send_word(CMD_RX_BYTE, NUL_BYTE, 1'($urandom));
		end else if (kind < 80) begin
			len = $urandom_range(6, 1);
			for (int i = 0; i < len; i++)
				send_word(CMD_TX_DATA, rand_byte(1'b0), $urandom_range(3) != 0);
			send_word(CMD_TX_TERM, 8'($urandom), 1'($urandom));
		end else begin
			send_word(cmd_t'($urandom_range(3)), 8'($urandom), 1'($urandom));
		end
	endtask

	// A receive frame of a given raw length, optionally ending on an escape byte.
	task automatic send_long_frame(input int len, input bit end_escaped);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			b = (end_escaped && i == len - 1) ? ESC_BYTE : rand_byte(1'b1);
			send_word(CMD_RX_BYTE, b, 1'($urandom));
		end
		send_word(CMD_RX_BYTE, NUL_BYTE, 1'($urandom));
	endtask

	// Receiver: random stalls, or a long hold-off when one is requested.
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < rcv_stall_pct);
			end
		end
	end

	// Compare each accepted result word with the oldest expected one.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_words.size() == 0) begin
				$error("unexpected result word: to_link %0h out_byte %0h last %0h oversize %0h",
					to_link, out_byte, last, oversize);
				errors++;
			end else begin
				want = pending_words.pop_front();
				if (to_link !== want.to_link) begin
					$error("to_link: expected %0h actual %0h", want.to_link, to_link);
					errors++;
				end
				if (out_byte !== want.out_byte) begin
					$error("out_byte: expected %0h actual %0h", want.out_byte, out_byte);
					errors++;
				end
				if (last !== want.last) begin
					$error("last: expected %0h actual %0h", want.last, last);
					errors++;
				end
				if (oversize !== want.oversize) begin
					$error("oversize: expected %0h actual %0h", want.oversize, oversize);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles in which neither side moves a word.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Timeout after %0d cycles without a handshake", quiet_cycles);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Reset, directed rows, then random sequences in two idling phases and a phase without idling.
	initial begin
		int base;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		src_idle_pct = 36;
		rcv_stall_pct = 86;
		foreach (directed_rows[i])
			drive_word(directed_rows[i].cmd, directed_rows[i].b, directed_rows[i].esc,
				directed_rows[i].typed, directed_rows[i].n, directed_rows[i].w0,
				directed_rows[i].w1);
		while (words_sent < 160)
			send_random_sequence();

		src_idle_pct = 86;
		rcv_stall_pct = 36;
		while (words_sent < 300)
			send_random_sequence();

		// No idling: long hold-off at the output while a frame past the limit goes in.
		src_idle_pct = 0;
		rcv_stall_pct = 0;
		hold_req = 1'b1;
		send_long_frame(FRAME_LIMIT + 2, 1'b1);
		base = words_sent;
		while (words_sent - base < 80)
			send_random_sequence();
		in_valid <= 1'b0;

		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d words in directed rows and random transmit and receive frames;",
			words_sent);
		$display("checked %0d result words, including a frame past %0d bytes and a long stall.",
			results_seen, FRAME_LIMIT);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ----- files.f -----
src/ebfc_pkg.sv
src/ebfc_codec.sv
src/ebfc_resq.sv
src/escaped_byte_framing_codec_core.sv
bench/testbench.sv
